FILE: rtl/core/deq_pkg.sv
package deq_pkg;

	// Word width of one queue entry
	localparam int unsigned WORD_W = 32;

	// Request codes
	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd1;
	localparam logic [1:0] REQ_PUSH_REAR  = 2'd2;
	localparam logic [1:0] REQ_POP_REAR   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic shift_right; // push front: every word moves one cell toward the rear
		logic shift_left;  // pop front: every word moves one cell toward the front
		logic load_rear;   // push rear: the first free cell takes the new word
	} cell_ctrl_t;

endpackage

FILE: rtl/core/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit words, held in a row of DEPTH cells.
// Request channel: req_valid / req_stall with req_type and value. A request
// pushes or pops at the front or at the rear of the queue.
// Response channel: rsp_valid / rsp_stall with data, status and fill. Every
// request gives exactly one response: the popped word (zero otherwise),
// status (ok, pop from empty, push into full) and the item count after it.
// The response is registered and shows in the cycle after the request is
// taken. One request per cycle is taken while the response is not stalled;
// the cells shift or load at once; the rear word is read on a one-hot bus.
// Front pushes and pops move every word one cell along the row, so the front
// always sits in cell 0 and the rear in cell (count - 1).
// Reset empties the queue (count zero) and clears the response valid; cell
// contents are not cleared and are never read before being written.
// While the receiver stalls a pending response, it holds and req_stall is
// raised, so no further request is taken until the response is accepted.
// A rejected push or an empty pop leaves the queue contents unchanged.
module double_ended_queue_unit #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] data,
	output logic [1:0]         status,
	output logic [4:0]         fill
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_nxt;
	logic                         rsp_valid_q;
	logic [deq_pkg::WORD_W-1:0]   data_q;
	logic [1:0]                   status_q;
	logic [4:0]                   fill_q;

	logic                         req_take;
	logic                         is_empty;
	logic                         is_full;
	deq_pkg::cell_ctrl_t          ctrl;
	logic [deq_pkg::WORD_W-1:0]   res_data;
	logic [1:0]                   res_status;
	logic [deq_pkg::WORD_W-1:0]   rear_word;

	logic [deq_pkg::WORD_W-1:0]   cell_word [DEPTH];
	logic [deq_pkg::WORD_W-1:0]   cell_tap  [DEPTH];

	// Handshake: one response slot, refilled as it drains
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_take  = req_valid && !req_stall;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));

	// Rear read bus: at most one cell drives a nonzero tap
	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | cell_tap[i];
		end
	end

	// Request decode
	always_comb begin
		ctrl       = '0;
		count_nxt  = count_q;
		res_data   = '0;
		res_status = deq_pkg::ST_OK;
		unique case (req_type)
			deq_pkg::REQ_PUSH_FRONT: begin
				if (is_full) begin
					res_status = deq_pkg::ST_FULL;
				end else begin
					ctrl.shift_right = req_take;
					count_nxt        = count_q + 1'b1;
				end
			end
			deq_pkg::REQ_PUSH_REAR: begin
				if (is_full) begin
					res_status = deq_pkg::ST_FULL;
				end else begin
					ctrl.load_rear = req_take;
					count_nxt      = count_q + 1'b1;
				end
			end
			deq_pkg::REQ_POP_FRONT: begin
				if (is_empty) begin
					res_status = deq_pkg::ST_EMPTY;
				end else begin
					ctrl.shift_left = req_take;
					res_data        = cell_word[0];
					count_nxt       = count_q - 1'b1;
				end
			end
			deq_pkg::REQ_POP_REAR: begin
				if (is_empty) begin
					res_status = deq_pkg::ST_EMPTY;
				end else begin
					res_data  = rear_word;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				res_status = deq_pkg::ST_OK;
			end
		endcase
	end

	// Row of storage cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [deq_pkg::WORD_W-1:0] left_w;
		logic [deq_pkg::WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		deq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.value      (value),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.rear_tap   (cell_tap[i])
		);
	end

	// Count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_take) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			data_q   <= res_data;
			status_q <= res_status;
			fill_q   <= 5'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign fill      = fill_q;

endmodule

FILE: rtl/core/deq_cell.sv
module deq_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  logic                           clk,
	input  deq_pkg::cell_ctrl_t            ctrl,
	input  logic [CW-1:0]                  count,
	input  logic [deq_pkg::WORD_W-1:0]     value,
	input  logic [deq_pkg::WORD_W-1:0]     left_word,
	input  logic [deq_pkg::WORD_W-1:0]     right_word,
	output logic [deq_pkg::WORD_W-1:0]     word,
	output logic [deq_pkg::WORD_W-1:0]     rear_tap
);

	logic [deq_pkg::WORD_W-1:0] word_q;
	logic                       is_free_head;
	logic                       is_rear;

	// Position of this cell relative to the occupied span
	assign is_free_head = (count == CW'(IDX));
	assign is_rear      = (count == CW'(IDX + 1));

	// Word storage, handed between neighbors
	always_ff @(posedge clk) begin
		if (ctrl.shift_right) begin
			word_q <= left_word;
		end else if (ctrl.shift_left) begin
			word_q <= right_word;
		end else if (ctrl.load_rear && is_free_head) begin
			word_q <= value;
		end
	end

	assign word     = word_q;
	// Only the last occupied cell drives the rear read bus
	assign rear_tap = is_rear ? word_q : '0;

endmodule

FILE: rtl/core/deq_checker.sv
module deq_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [31:0] data,
	input logic [1:0]         status,
	input logic [4:0]         fill
);

	// A stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(data) && $stable(status)
			&& $stable(fill))
		else $error("stalled response changed");

	// Every taken request produces a response in the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("request taken without a response");

	// A rejected push reports a full queue and no data
	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == deq_pkg::ST_FULL |-> data == '0 && fill == 5'(DEPTH))
		else $error("bad full response");

	// An empty pop reports an empty queue and no data
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == deq_pkg::ST_EMPTY |-> data == '0 && fill == '0)
		else $error("bad empty response");

	// Request stall only while a response is pending
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a pending response");

endmodule

bind double_ended_queue_unit deq_checker #(
	.DEPTH (DEPTH)
) u_deq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.data      (data),
	.status    (status),
	.fill      (fill)
);
